// File: src/osrt_pkg.sv
// Package for the operand stack with rotate and tuck.
// Holds sizes, request codes and the cell command struct; no dependencies.
`default_nettype none
package osrt_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int WORD_W      = 32;
    localparam int DARG_W      = 7;
    localparam int OCC_W       = 7;
    localparam int CMP_W       = (CNT_W > DARG_W) ? CNT_W : DARG_W;
    localparam int REQ_W       = 3;
    localparam int S_TDATA_W   = ((WORD_W + DARG_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((WORD_W + OCC_W + 3 + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_PEEK   = 3'd2,
        REQ_ROTATE = 3'd3,
        REQ_TUCK   = 3'd4,
        REQ_DUP    = 3'd5,
        REQ_CLEAR  = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        MV_HOLD,
        MV_PUSH,
        MV_DUP,
        MV_POP,
        MV_ROT,
        MV_TUCK
    } mov_t;

    typedef struct packed {
        mov_t             mode;
        logic [CMP_W-1:0] n;
        logic [IDX_W-1:0] sel;
    } cell_cmd_t;
endpackage
`default_nettype wire

// File: src/osrt_cell.sv
// One stack cell holding the word at a fixed depth from the top.
// Uses osrt_pkg; neighbors hand words up or down under the shared command.
`default_nettype none
module osrt_cell
    import osrt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire cell_cmd_t                cmd,
    input  wire logic                     step_en,
    input  wire logic [IDX_W-1:0]         cell_idx,
    input  wire logic signed [WORD_W-1:0] push_value,
    input  wire logic signed [WORD_W-1:0] bus_value,
    input  wire logic signed [WORD_W-1:0] above_value,
    input  wire logic signed [WORD_W-1:0] below_value,
    input  wire logic signed [WORD_W-1:0] top_value,
    output logic signed [WORD_W-1:0]      value_out,
    output logic signed [WORD_W-1:0]      bus_term
);
    logic signed [WORD_W-1:0] value_reg;
    logic signed [WORD_W-1:0] value_next;
    logic [CMP_W-1:0]         idx_ext;
    logic                     is_top;

    assign idx_ext = CMP_W'(cell_idx);
    assign is_top  = (cell_idx == '0);

    always_comb begin
        value_next = value_reg;
        unique case (cmd.mode)
            MV_PUSH: value_next = is_top ? push_value : above_value;
            MV_DUP:  value_next = is_top ? bus_value : above_value;
            MV_POP:  value_next = below_value;
            MV_ROT: begin
                if (idx_ext < cmd.n) begin
                    value_next = is_top ? bus_value : above_value;
                end
            end
            MV_TUCK: begin
                if (idx_ext + CMP_W'(1) < cmd.n) begin
                    value_next = below_value;
                end else if (idx_ext + CMP_W'(1) == cmd.n) begin
                    value_next = top_value;
                end
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            value_reg <= value_next;
        end
    end

    assign value_out = value_reg;
    assign bus_term  = (cmd.sel == cell_idx) ? value_reg : '0;
endmodule
`default_nettype wire

// File: src/osrt_ctrl.sv
// Request decode for the operand stack: fault checks, next count, cell command.
// Uses osrt_pkg; purely combinational.
`default_nettype none
module osrt_ctrl
    import osrt_pkg::*;
(
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [DARG_W-1:0] depth_arg,
    input  wire logic [CNT_W-1:0]  count,
    output cell_cmd_t              cmd,
    output logic                   fault,
    output logic                   read_en,
    output logic [CNT_W-1:0]       count_next
);
    logic [CMP_W-1:0] d_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             empty;

    assign d_ext   = CMP_W'(depth_arg);
    assign cnt_ext = CMP_W'(count);
    assign full    = (cnt_ext >= CMP_W'(STACK_DEPTH));
    assign empty   = (count == '0);

    always_comb begin
        cmd.mode   = MV_HOLD;
        cmd.n      = d_ext;
        cmd.sel    = d_ext[IDX_W-1:0];
        fault      = 1'b0;
        read_en    = 1'b0;
        count_next = count;
        unique case (req_t'(req_type))
            REQ_PUSH: begin
                fault = full;
                if (!full) begin
                    cmd.mode   = MV_PUSH;
                    count_next = count + CNT_W'(1);
                end
            end
            REQ_POP: begin
                fault   = empty;
                cmd.sel = '0;
                if (!empty) begin
                    cmd.mode   = MV_POP;
                    read_en    = 1'b1;
                    count_next = count - CNT_W'(1);
                end
            end
            REQ_PEEK: begin
                fault   = (d_ext >= cnt_ext);
                read_en = !fault;
            end
            REQ_ROTATE: begin
                fault   = (d_ext > cnt_ext);
                cmd.sel = IDX_W'(d_ext - CMP_W'(1));
                if (!fault && d_ext > CMP_W'(1)) begin
                    cmd.mode = MV_ROT;
                end
            end
            REQ_TUCK: begin
                fault = (d_ext > cnt_ext);
                if (!fault && d_ext > CMP_W'(1)) begin
                    cmd.mode = MV_TUCK;
                end
            end
            REQ_DUP: begin
                fault = (d_ext >= cnt_ext) || full;
                if (!fault) begin
                    cmd.mode   = MV_DUP;
                    count_next = count + CNT_W'(1);
                end
            end
            REQ_CLEAR: begin
                count_next = '0;
            end
            default: begin
                fault = 1'b1;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: src/operand_stack_with_rotate_tuck_unit.sv
// Operand stack with rotate, tuck and duplicate, built as a row of word cells.
// Output: the result is registered at the edge that accepts the item.
// Throughput: one item per cycle; the output register stalls intake only while
// a result waits on m_tready. All cells shift together at the edge that accepts an item.
// Reset: entry count and output valid clear; cell words stay undefined until pushed.
// Depends on osrt_pkg, osrt_ctrl and osrt_cell.
`default_nettype none
module operand_stack_with_rotate_tuck_unit
    import osrt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] push_value, [38:32] depth_arg, rest zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] req_type
    input  wire logic [REQ_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] read_value, [38:32] occupancy, [39] is_full, [40] is_empty,
    // [41] fault, rest zero
    output logic [M_TDATA_W-1:0]      m_tdata
);
    logic                     accept;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;
    cell_cmd_t                cmd;
    logic                     fault;
    logic                     read_en;
    logic signed [WORD_W-1:0] push_value;
    logic [DARG_W-1:0]        depth_arg;
    logic signed [WORD_W-1:0] cell_value [STACK_DEPTH];
    logic signed [WORD_W-1:0] cell_term  [STACK_DEPTH];
    logic signed [WORD_W-1:0] bus_value;
    logic signed [WORD_W-1:0] read_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_full;
    logic                     is_empty;

    assign push_value = s_tdata[WORD_W-1:0];
    assign depth_arg  = s_tdata[WORD_W+DARG_W-1:WORD_W];
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;

    osrt_ctrl u_ctrl (
        .req_type   (s_tuser),
        .depth_arg  (depth_arg),
        .count      (count_reg),
        .cmd        (cmd),
        .fault      (fault),
        .read_en    (read_en),
        .count_next (count_next)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic signed [WORD_W-1:0] above;
        logic signed [WORD_W-1:0] below;
        if (i == 0) begin : g_first
            assign above = '0;
        end else begin : g_mid
            assign above = cell_value[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_last
            assign below = '0;
        end else begin : g_inner
            assign below = cell_value[i+1];
        end
        osrt_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .step_en     (accept),
            .cell_idx    (IDX_W'(i)),
            .push_value  (push_value),
            .bus_value   (bus_value),
            .above_value (above),
            .below_value (below),
            .top_value   (cell_value[0]),
            .value_out   (cell_value[i]),
            .bus_term    (cell_term[i])
        );
    end

    always_comb begin
        bus_value = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            bus_value = bus_value | cell_term[i];
        end
    end

    assign read_value = read_en ? bus_value : '0;
    assign occupancy  = OCC_W'(CMP_W'(count_next));
    assign is_full    = (CMP_W'(count_next) >= CMP_W'(STACK_DEPTH));
    assign is_empty   = (count_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= M_TDATA_W'({fault, is_empty, is_full, occupancy, read_value});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(STACK_DEPTH))
        else $error("entry count beyond capacity");

    a_fault_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fault |=> $stable(count_reg))
        else $error("refused request changed the entry count");

    a_occ_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WORD_W+OCC_W-1:WORD_W] == OCC_W'(CMP_W'(count_reg))))
        else $error("reported occupancy differs from entry count");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WORD_W+OCC_W+1] == (count_reg == '0)))
        else $error("empty flag differs from entry count");
endmodule
`default_nettype wire
